// File: hw/rtl/mec_pkg.sv
// Shared types, constants and helper functions of the motion event classifier.
package mec_pkg;

  localparam int unsigned OneG = 4096;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHAKE  = 2'd1,
    EV_PICKUP = 2'd2,
    EV_STILL  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CFG_FILTER_GAIN      = 3'd0,
    CFG_SHAKE_THRESHOLD  = 3'd1,
    CFG_PICKUP_THRESHOLD = 3'd2,
    CFG_TILT_THRESHOLD   = 3'd3,
    CFG_MOTION_THRESHOLD = 3'd4,
    CFG_SHAKE_COOLDOWN   = 3'd5,
    CFG_PICKUP_COOLDOWN  = 3'd6,
    CFG_STILL_TIMEOUT    = 3'd7
  } cfg_idx_e;

  // Squared magnitude bounds for one deviation threshold
  typedef struct packed {
    logic [30:0] hi_sq;
    logic [24:0] lo_sq;
    logic        lo_en;
  } dev_bound_t;

  typedef struct packed {
    logic [7:0]  gain;
    dev_bound_t  shake;
    dev_bound_t  pickup;
    dev_bound_t  motion;
    logic [14:0] tilt;
    logic [31:0] shake_cd;
    logic [31:0] pickup_cd;
    logic [31:0] still_to;
  } cfg_t;

  // (1g + t)^2 and, for t below 1g, (1g - t)^2
  function automatic dev_bound_t mk_bound(input logic [14:0] thr);
    logic [15:0] hi;
    logic [12:0] lo;
    logic [31:0] hi_p;
    logic [25:0] lo_p;
    dev_bound_t  b;
    hi      = 16'(OneG) + {1'b0, thr};
    lo      = 13'(OneG) - {1'b0, thr[11:0]};
    hi_p    = 32'(hi) * 32'(hi);
    lo_p    = 26'(lo) * 26'(lo);
    b.hi_sq = hi_p[30:0];
    b.lo_sq = lo_p[24:0];
    b.lo_en = (thr[14:12] == 3'd0);
    return b;
  endfunction

  function automatic logic dev_above(input logic [31:0] s, input dev_bound_t b);
    return (s > {1'b0, b.hi_sq}) || (b.lo_en && (s < {7'd0, b.lo_sq}));
  endfunction

  localparam cfg_t CfgRst = '{
    gain:      8'd46,
    shake:     mk_bound(15'd3072),
    pickup:    mk_bound(15'd737),
    motion:    mk_bound(15'd205),
    tilt:      15'd819,
    shake_cd:  32'd1000,
    pickup_cd: 32'd2000,
    still_to:  32'd60000
  };

endpackage

// File: hw/rtl/motion_event_classifier_unit.sv
// Motion event classifier: three-stage pipeline with configuration registers.
//
// Input channel (in_valid_i / in_ready_o) takes one accelerometer sample with
// its millisecond timestamp per beat. Output channel (out_valid_o /
// out_ready_i) gives exactly one result beat per sample, in order: an event
// code (none, shake, pickup, still) and two clamped gaze offsets.
// Stages: the sample and its three squares are registered, then the filter
// and classifier update the state and register the event, then the gaze
// offsets are formed from the filtered tilt into the output register.
// A beat passes from stage A to stage B and then into the output
// register. Throughput is one sample per cycle while the output is not
// stalled; the filter feedback and classifier decision close within the
// middle stage, which sets that figure.
// Each stage holds its beat only while the stage after it is full and
// stalled, so the block keeps taking samples into empty stages while a
// result waits; in_ready_o drops once all three stages hold beats and
// out_ready_i is low.
// Reset clears the pipeline, the filter and timing state, and loads the
// default configuration. Configuration writes (cfg_we_i) take effect at the
// next edge and are meant for an idle block.
module motion_event_classifier_unit import mec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         event_code_o,
  output logic signed [3:0]  gaze_x_o,
  output logic signed [2:0]  gaze_y_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  // Configuration
  cfg_t       cfg_q, cfg_d;
  dev_bound_t wr_bound;

  assign wr_bound = mk_bound(cfg_wdata_i[14:0]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FILTER_GAIN:      cfg_d.gain      = cfg_wdata_i[7:0];
        CFG_SHAKE_THRESHOLD:  cfg_d.shake     = wr_bound;
        CFG_PICKUP_THRESHOLD: cfg_d.pickup    = wr_bound;
        CFG_TILT_THRESHOLD:   cfg_d.tilt      = cfg_wdata_i[14:0];
        CFG_MOTION_THRESHOLD: cfg_d.motion    = wr_bound;
        CFG_SHAKE_COOLDOWN:   cfg_d.shake_cd  = cfg_wdata_i;
        CFG_PICKUP_COOLDOWN:  cfg_d.pickup_cd = cfg_wdata_i;
        CFG_STILL_TIMEOUT:    cfg_d.still_to  = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline control
  logic a_valid_q, b_valid_q, out_valid_q;
  logic a_ready, b_ready, c_ready;
  logic in_fire, step;

  assign c_ready    = !out_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;
  assign in_fire    = in_valid_i && a_ready;
  assign step       = a_valid_q && b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q   <= in_valid_i;
      if (b_ready) b_valid_q   <= a_valid_q;
      if (c_ready) out_valid_q <= b_valid_q;
    end
  end

  // Stage A: sample and squares
  logic signed [15:0] ax_q, ay_q, az_q;
  logic [31:0]        now_q;
  logic [30:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [31:0]        sq_x_d, sq_y_d, sq_z_d;

  assign sq_x_d = 32'(accel_x_i) * 32'(accel_x_i);
  assign sq_y_d = 32'(accel_y_i) * 32'(accel_y_i);
  assign sq_z_d = 32'(accel_z_i) * 32'(accel_z_i);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q   <= accel_x_i;
      ay_q   <= accel_y_i;
      az_q   <= accel_z_i;
      now_q  <= now_ms_i;
      sq_x_q <= sq_x_d[30:0];
      sq_y_q <= sq_y_d[30:0];
      sq_z_q <= sq_z_d[30:0];
    end
  end

  // Stage B: filter and classify
  event_e             core_event;
  event_e             event_q;
  logic signed [23:0] filt_x, filt_y;

  mec_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg_q),
    .ax_i     (ax_q),
    .ay_i     (ay_q),
    .az_i     (az_q),
    .sq_x_i   (sq_x_q),
    .sq_y_i   (sq_y_q),
    .sq_z_i   (sq_z_q),
    .now_i    (now_q),
    .event_o  (core_event),
    .filt_x_o (filt_x),
    .filt_y_o (filt_y)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      event_q <= core_event;
    end
  end

  // Stage C: gaze offsets. The filter state always belongs to the beat in
  // stage B, since the state advances only when a beat enters that stage.
  logic signed [27:0] fx_w, fy_w, gx_m, gy_m, gx_t, gy_t;
  logic signed [7:0]  gx_s, gy_s;
  logic signed [3:0]  gaze_x_d, gaze_x_q;
  logic signed [2:0]  gaze_y_d, gaze_y_q;
  logic [1:0]         event_code_q;

  always_comb begin
    fx_w = 28'(filt_x);
    fy_w = 28'(filt_y);
    gx_m = (fx_w <<< 3) + fx_w;
    gy_m = fy_w - (fy_w <<< 3);
    // Round toward zero on the divide by 2^20
    gx_t = gx_m + (gx_m[27] ? 28'sd1048575 : 28'sd0);
    gy_t = gy_m + (gy_m[27] ? 28'sd1048575 : 28'sd0);
    gx_s = gx_t[27:20];
    gy_s = gy_t[27:20];
    priority if (gx_s > 8'sd4) begin
      gaze_x_d = 4'sd4;
    end else if (gx_s < -8'sd4) begin
      gaze_x_d = -4'sd4;
    end else begin
      gaze_x_d = gx_s[3:0];
    end
    priority if (gy_s > 8'sd3) begin
      gaze_y_d = 3'sd3;
    end else if (gy_s < -8'sd3) begin
      gaze_y_d = -3'sd3;
    end else begin
      gaze_y_d = gy_s[2:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_ready) begin
      event_code_q <= event_q;
      gaze_x_q     <= gaze_x_d;
      gaze_y_q     <= gaze_y_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = event_code_q;
  assign gaze_x_o     = gaze_x_q;
  assign gaze_y_o     = gaze_y_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && b_valid_q && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while all stages are full and stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(b_valid_q))
    else $error("result beat appeared without a classified beat behind it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(b_valid_q) |-> $past(a_valid_q))
    else $error("classify stage filled without a sample beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((gaze_x_o <= 4'sd4) && (gaze_x_o >= -4'sd4) &&
                     (gaze_y_o <= 3'sd3) && (gaze_y_o >= -3'sd3)))
    else $error("gaze offset outside its clamp range");
`endif

endmodule

// File: hw/rtl/mec_core.sv
// Low-pass filter state and event classification of one sample per step.
module mec_core import mec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  cfg_t               cfg_i,
  input  logic signed [15:0] ax_i,
  input  logic signed [15:0] ay_i,
  input  logic signed [15:0] az_i,
  input  logic [30:0]        sq_x_i,
  input  logic [30:0]        sq_y_i,
  input  logic [30:0]        sq_z_i,
  input  logic [31:0]        now_i,
  output event_e             event_o,
  output logic signed [23:0] filt_x_o,
  output logic signed [23:0] filt_y_o
);

  logic signed [23:0] filt_x_q, filt_x_d, filt_y_q, filt_y_d;
  logic signed [15:0] rest_z_q, rest_z_d, rest_eff;
  logic               rest_known_q;
  logic [31:0]        last_shake_q, last_shake_d;
  logic [31:0]        last_pickup_q, last_pickup_d;
  logic [31:0]        last_motion_q, last_motion_d;

  logic [31:0]        mag_sq;
  logic               shake_dev, pickup_dev, motion_dev;
  logic signed [16:0] dz_s;
  logic [16:0]        dz_abs;
  logic               tilt_hit;
  logic [31:0]        el_shake, el_pickup, el_motion;
  event_e             event_d;

  function automatic logic signed [23:0] lowpass(input logic signed [23:0] f,
                                                 input logic signed [15:0] a,
                                                 input logic [7:0] g);
    logic signed [24:0] diff;
    logic signed [33:0] prod;
    logic signed [25:0] step;
    diff = {a[15], a, 8'h00} - {f[23], f};
    prod = 34'(diff) * 34'($signed({1'b0, g}));
    step = prod[33:8];
    return f + step[23:0];
  endfunction

  assign filt_x_d = lowpass(filt_x_q, ax_i, cfg_i.gain);
  assign filt_y_d = lowpass(filt_y_q, ay_i, cfg_i.gain);

  assign mag_sq     = {1'b0, sq_x_i} + {1'b0, sq_y_i} + {1'b0, sq_z_i};
  assign shake_dev  = dev_above(mag_sq, cfg_i.shake);
  assign pickup_dev = dev_above(mag_sq, cfg_i.pickup);
  assign motion_dev = dev_above(mag_sq, cfg_i.motion);

  // The first sample becomes the rest reference before the tests
  assign rest_eff = rest_known_q ? rest_z_q : az_i;
  assign dz_s     = 17'(az_i) - 17'(rest_eff);
  assign dz_abs   = dz_s[16] ? 17'(-dz_s) : 17'(dz_s);
  assign tilt_hit = dz_abs > {2'b00, cfg_i.tilt};

  assign el_shake  = now_i - last_shake_q;
  assign el_pickup = now_i - last_pickup_q;
  assign el_motion = now_i - last_motion_q;

  always_comb begin
    event_d       = EV_NONE;
    rest_z_d      = rest_eff;
    last_shake_d  = last_shake_q;
    last_pickup_d = last_pickup_q;
    last_motion_d = last_motion_q;
    priority if (shake_dev && (el_shake > cfg_i.shake_cd)) begin
      event_d       = EV_SHAKE;
      last_shake_d  = now_i;
      last_motion_d = now_i;
    end else if (pickup_dev && !shake_dev && tilt_hit &&
                 (el_pickup > cfg_i.pickup_cd)) begin
      event_d       = EV_PICKUP;
      last_pickup_d = now_i;
      last_motion_d = now_i;
      rest_z_d      = az_i;
    end else if (motion_dev) begin
      last_motion_d = now_i;
    end else if (el_motion > cfg_i.still_to) begin
      event_d       = EV_STILL;
      last_motion_d = now_i;
    end else begin
      event_d = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_x_q      <= '0;
      filt_y_q      <= '0;
      rest_z_q      <= '0;
      rest_known_q  <= 1'b0;
      last_shake_q  <= '0;
      last_pickup_q <= '0;
      last_motion_q <= '0;
    end else if (step_i) begin
      filt_x_q      <= filt_x_d;
      filt_y_q      <= filt_y_d;
      rest_z_q      <= rest_z_d;
      rest_known_q  <= 1'b1;
      last_shake_q  <= last_shake_d;
      last_pickup_q <= last_pickup_d;
      last_motion_q <= last_motion_d;
    end
  end

  assign event_o  = event_d;
  assign filt_x_o = filt_x_q;
  assign filt_y_o = filt_y_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the motion event classifier, directed and random samples.
module tb_top import mec_pkg::*; ();

  typedef struct {
    event_e            ev;
    logic signed [3:0] gaze_x;
    logic signed [2:0] gaze_y;
  } motion_result_t;

  localparam logic signed [15:0] AccMin = 16'sh8000;
  localparam logic signed [15:0] AccMax = 16'sh7FFF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] accel_x_i = '0;
  logic signed [15:0] accel_y_i = '0;
  logic signed [15:0] accel_z_i = '0;
  logic [31:0]        now_ms_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         event_code_o;
  logic signed [3:0]  gaze_x_o;
  logic signed [2:0]  gaze_y_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_wdata_i = '0;

  // Predictor copy of the configuration
  logic [7:0]  gain_cfg;
  logic [14:0] shake_thr_cfg, pickup_thr_cfg, tilt_thr_cfg, motion_thr_cfg;
  logic [31:0] shake_cd_cfg, pickup_cd_cfg, still_to_cfg;

  // Predictor copy of the state
  logic signed [23:0] lp_x, lp_y;
  logic signed [15:0] rest_level_z;
  logic               rest_seen;
  logic [31:0]        shake_stamp, pickup_stamp, motion_stamp;

  motion_result_t expected_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    sender_gap_max = 7;
  int unsigned    sink_stall_max = 7;
  int unsigned    sink_hold_cycles = 0;
  logic [31:0]    sample_time = '0;

  always #1 clk_i = ~clk_i;

  motion_event_classifier_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_code_o (event_code_o),
    .gaze_x_o     (gaze_x_o),
    .gaze_y_o     (gaze_y_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // f + floor((a*256 - f) * gain / 256)
  function automatic logic signed [23:0] lowpass_step(logic signed [23:0] f,
                                                      logic signed [15:0] a);
    longint diff;
    diff = (longint'(a) <<< 8) - longint'(f);
    return 24'(longint'(f) + ((diff * longint'(gain_cfg)) >>> 8));
  endfunction

  // True when the magnitude differs from 1 g by more than thr
  function automatic bit deviation_over(longint sq, logic [14:0] thr);
    longint hi, lo;
    hi = longint'(OneG) + longint'(thr);
    lo = longint'(OneG) - longint'(thr);
    return (sq > hi * hi) || ((thr < 15'd4096) && (sq < lo * lo));
  endfunction

  function automatic bit elapsed_over(logic [31:0] now, logic [31:0] last,
                                      logic [31:0] lim);
    logic [31:0] span;
    span = now - last;
    return span > lim;
  endfunction

  function automatic motion_result_t classify_sample(logic signed [15:0] ax,
                                                     logic signed [15:0] ay,
                                                     logic signed [15:0] az,
                                                     logic [31:0] now);
    motion_result_t r;
    longint sq, gx, gy, dz;
    lp_x = lowpass_step(lp_x, ax);
    lp_y = lowpass_step(lp_y, ay);
    gx = (longint'(lp_x) * 9) / 1048576;
    gy = (longint'(lp_y) * -7) / 1048576;
    if (gx > 4) gx = 4;
    else if (gx < -4) gx = -4;
    if (gy > 3) gy = 3;
    else if (gy < -3) gy = -3;
    r.gaze_x = 4'(gx);
    r.gaze_y = 3'(gy);

    sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    if (!rest_seen) begin
      rest_level_z = az;
      rest_seen = 1'b1;
    end
    dz = longint'(az) - longint'(rest_level_z);
    if (dz < 0) dz = -dz;

    r.ev = EV_NONE;
    if (deviation_over(sq, shake_thr_cfg) &&
        elapsed_over(now, shake_stamp, shake_cd_cfg)) begin
      shake_stamp = now;
      motion_stamp = now;
      r.ev = EV_SHAKE;
    end else if (deviation_over(sq, pickup_thr_cfg) && !deviation_over(sq, shake_thr_cfg) &&
                 dz > longint'(tilt_thr_cfg) &&
                 elapsed_over(now, pickup_stamp, pickup_cd_cfg)) begin
      pickup_stamp = now;
      motion_stamp = now;
      rest_level_z = az;
      r.ev = EV_PICKUP;
    end else if (deviation_over(sq, motion_thr_cfg)) begin
      motion_stamp = now;
    end else if (elapsed_over(now, motion_stamp, still_to_cfg)) begin
      motion_stamp = now;
      r.ev = EV_STILL;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] az, input logic [31:0] now);
    int unsigned gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    accel_x_i  <= ax;
    accel_y_i  <= ay;
    accel_z_i  <= az;
    now_ms_i   <= now;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o === 1'b1));
    expected_results.push_back(classify_sample(ax, ay, az, now));
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_FILTER_GAIN:      gain_cfg       = data[7:0];
      CFG_SHAKE_THRESHOLD:  shake_thr_cfg  = data[14:0];
      CFG_PICKUP_THRESHOLD: pickup_thr_cfg = data[14:0];
      CFG_TILT_THRESHOLD:   tilt_thr_cfg   = data[14:0];
      CFG_MOTION_THRESHOLD: motion_thr_cfg = data[14:0];
      CFG_SHAKE_COOLDOWN:   shake_cd_cfg   = data;
      CFG_PICKUP_COOLDOWN:  pickup_cd_cfg  = data;
      CFG_STILL_TIMEOUT:    still_to_cfg   = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] gain, input logic [31:0] shake_thr,
                                input logic [31:0] pickup_thr, input logic [31:0] tilt_thr,
                                input logic [31:0] motion_thr, input logic [31:0] shake_cd,
                                input logic [31:0] pickup_cd, input logic [31:0] still_to);
    wait_drained();
    write_reg(CFG_FILTER_GAIN, gain);
    write_reg(CFG_SHAKE_THRESHOLD, shake_thr);
    write_reg(CFG_PICKUP_THRESHOLD, pickup_thr);
    write_reg(CFG_TILT_THRESHOLD, tilt_thr);
    write_reg(CFG_MOTION_THRESHOLD, motion_thr);
    write_reg(CFG_SHAKE_COOLDOWN, shake_cd);
    write_reg(CFG_PICKUP_COOLDOWN, pickup_cd);
    write_reg(CFG_STILL_TIMEOUT, still_to);
  endtask

  function automatic logic signed [15:0] jitter(int center, int unsigned span);
    int v;
    v = center + int'($urandom_range(0, 2 * span)) - int'(span);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Mostly plausible motion with timestamps that mostly move forward, plus noise
  task automatic send_random(input int unsigned count);
    logic signed [15:0] acc [0:2];
    int unsigned        kind, pick, span, axis;
    int                 up;
    int                 i;
    repeat (count) begin
      kind = $urandom_range(0, 9);
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        sample_time += $urandom_range(0, 60);
      end else if (pick < 15) begin
        sample_time += $urandom_range(0, 2500);
      end else if (pick < 17) begin
        // quiet sample right at the still timeout edge
        sample_time = motion_stamp + still_to_cfg + $urandom_range(0, 1);
        kind = 0;
      end else if (pick == 17) begin
        sample_time = shake_stamp + shake_cd_cfg + $urandom_range(0, 1);
      end else if (pick == 18) begin
        sample_time = pickup_stamp + pickup_cd_cfg + $urandom_range(0, 1);
      end else begin
        sample_time = $urandom;
      end

      case (kind)
        0, 1, 2, 3: begin
          span = (kind == 0) ? 60 : ((kind == 1) ? 300 : 1200);
          axis = $urandom_range(0, 2);
          up   = ($urandom_range(0, 1) != 0) ? int'(OneG) : -int'(OneG);
          for (i = 0; i < 3; i++) acc[i] = jitter((i == int'(axis)) ? up : 0, span);
        end
        4, 5: begin
          up = ($urandom_range(0, 4) != 0) ? 4500 : -4500;
          acc[0] = jitter(0, 200);
          acc[1] = jitter(0, 200);
          acc[2] = jitter(up, 2500);
        end
        6: begin
          for (i = 0; i < 3; i++) acc[i] = 16'($urandom);
        end
        7: begin
          for (i = 0; i < 3; i++) acc[i] = jitter(0, 12000);
        end
        8: begin
          for (i = 0; i < 3; i++) begin
            case ($urandom_range(0, 6))
              0: acc[i] = AccMin;
              1: acc[i] = AccMax;
              2: acc[i] = -16'sd4096;
              3: acc[i] = 16'sd4096;
              4: acc[i] = -16'sd1;
              5: acc[i] = 16'sd1;
              default: acc[i] = 16'sd0;
            endcase
          end
        end
        default: begin
          // near free fall
          for (i = 0; i < 3; i++) acc[i] = jitter(0, 1500);
        end
      endcase
      send_sample(acc[0], acc[1], acc[2], sample_time);
    end
  endtask

  // Result side: random stalls, long hold when asked, check every beat
  initial begin : result_sink
    int unsigned    stall;
    motion_result_t want;
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_ready_i));
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: event %0d gaze %0d/%0d",
                                  event_code_o, gaze_x_o, gaze_y_o));
      end else begin
        want = expected_results.pop_front();
        if (event_code_o !== want.ev)
          report_mismatch($sformatf("event_code got %0d want %0d", event_code_o, want.ev));
        if (gaze_x_o !== want.gaze_x)
          report_mismatch($sformatf("gaze_x got %0d want %0d", gaze_x_o, want.gaze_x));
        if (gaze_y_o !== want.gaze_y)
          report_mismatch($sformatf("gaze_y got %0d want %0d", gaze_y_o, want.gaze_y));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_defaults();
    send_sample(16'sd0, 16'sd0, 16'sd4096, 32'd100);      // first sample latches rest z
    send_sample(AccMax, AccMin, AccMax, 32'd1500);        // shake, gaze clamps
    send_sample(AccMin, AccMax, AccMin, 32'd1600);        // shake in cooldown falls through
    send_sample(16'sd0, 16'sd0, 16'sd6144, 32'd3000);     // pickup
    send_sample(16'sd0, 16'sd0, 16'sd6144, 32'd3100);     // no tilt from new rest
    send_sample(16'sd0, 16'sd0, 16'sd2048, 32'd3200);     // pickup in cooldown
    send_sample(16'sd0, 16'sd0, 16'sd2048, 32'd5201);     // pickup again
    send_sample(16'sd0, 16'sd0, 16'sd4096, 32'd65201);    // exactly at still timeout
    send_sample(16'sd0, 16'sd0, 16'sd4096, 32'd65202);    // still
    send_sample(16'sd0, 16'sd4096, 16'sd0, 32'd65203);
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'd65300);       // free fall counts as shake
    send_sample(16'sd4096, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
    send_sample(16'sd0, -16'sd4096, 16'sd0, 32'd59999);   // timestamp wrapped, at edge
    send_sample(16'sd0, -16'sd4096, 16'sd0, 32'd60000);
    send_sample(16'sd20000, 16'sd0, 16'sd0, 32'd0);       // shake across the wrap
    send_sample(16'sd0, 16'sd0, 16'sd4896, 32'd1000);
    send_sample(16'sd0, 16'sd0, 16'sd5715, 32'd4000);     // tilt exactly at threshold
    send_sample(16'sd0, 16'sd0, 16'sd5716, 32'd4001);
    send_sample(16'sd7168, 16'sd0, 16'sd0, 32'd5000);     // deviation exactly at shake level
    send_sample(16'sd7169, 16'sd0, 16'sd0, 32'd5002);
    send_sample(AccMin, AccMin, AccMin, 32'd9000);
    send_sample(AccMax, AccMax, AccMax, 32'd9001);
    sample_time = 32'd9001;
  endtask

  task automatic test_random_defaults();
    send_random(250);
  endtask

  // Values wider than the registers: only the low bits count
  task automatic test_sensitive_settings();
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_8000, 32'h0001_0000, 32'h0000_8000,
                   32'd0, 32'd0, 32'd0, 32'd0);
    send_random(200);
  endtask

  task automatic test_max_settings();
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(200);
  endtask

  task automatic test_zero_gain();
    apply_settings(32'd0, 32'd4096, 32'd4095, 32'd0, 32'd1, 32'd1, 32'd2, 32'd100);
    sample_time += 32'd10;
    send_sample(16'sd0, 16'sd0, 16'sd0, sample_time);
    send_sample(AccMax, AccMin, AccMax, sample_time + 32'd5);
    send_sample(16'sd0, 16'sd0, 16'sd0, sample_time + 32'd10);
    sample_time += 32'd10;
    send_random(200);
  endtask

  task automatic test_busy_settings();
    apply_settings(32'd128, 32'd2000, 32'd500, 32'd300, 32'd100, 32'd20, 32'd40, 32'd200);
    send_random(300);
  endtask

  task automatic test_backpressure();
    wait_drained();
    sink_hold_cycles = 60;
    sender_gap_max   = 0;
    send_random(30);
    // hold the sender until every result is back
    wait_drained();
    sink_stall_max = 0;
    send_random(150);
    wait_drained();
    sender_gap_max = 7;
    sink_stall_max = 7;
  endtask

  task automatic test_restore_defaults();
    apply_settings(32'd46, 32'd3072, 32'd737, 32'd819, 32'd205, 32'd1000, 32'd2000,
                   32'd60000);
    send_random(300);
  endtask

  initial begin
    gain_cfg       = 8'd46;
    shake_thr_cfg  = 15'd3072;
    pickup_thr_cfg = 15'd737;
    tilt_thr_cfg   = 15'd819;
    motion_thr_cfg = 15'd205;
    shake_cd_cfg   = 32'd1000;
    pickup_cd_cfg  = 32'd2000;
    still_to_cfg   = 32'd60000;
    lp_x           = '0;
    lp_y           = '0;
    rest_level_z   = '0;
    rest_seen      = 1'b0;
    shake_stamp    = '0;
    pickup_stamp   = '0;
    motion_stamp   = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_random_defaults();
    test_sensitive_settings();
    test_max_settings();
    test_zero_gain();
    test_busy_settings();
    test_backpressure();
    test_restore_defaults();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
